// ----- design/lcc_pkg.sv -----
package lcc_pkg;

  // lane count and field widths
  localparam int NUM_LANES   = 8;
  localparam int COEFF_W     = 13;
  localparam int DCOEFF_W    = 12;
  localparam int CODE_W      = 5;
  localparam int PACKED_W    = 40;

  // register indexes on the config port
  localparam logic [1:0] REG_WIDTH_MODE = 2'd0;
  localparam logic [1:0] REG_DIRECTION  = 2'd1;

  // width mode codes (code three behaves as five bits)
  localparam logic [1:0] WM_D1 = 2'd0;
  localparam logic [1:0] WM_D4 = 2'd1;
  localparam logic [1:0] WM_D5 = 2'd2;

  // direction codes
  localparam logic DIR_COMPRESS   = 1'b0;
  localparam logic DIR_DECOMPRESS = 1'b1;

  // modulus and compression constants
  localparam logic [13:0] KQ    = 14'd3329;
  localparam logic [31:0] RND4  = 32'd1665;
  localparam logic [16:0] MUL4  = 17'd80635;
  localparam logic [31:0] RND5  = 32'd1664;
  localparam logic [16:0] MUL5  = 17'd40318;
  localparam logic [17:0] HALFQ = 18'd1664;
  // ceil(2^30 / q), exact quotient for dividends below 2^18
  localparam logic [18:0] RECIP_Q  = 19'd322542;
  localparam int          RECIP_SH = 30;

  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [DCOEFF_W-1:0] dcoeff_t;

  // per-word control carried down the pipe
  typedef struct packed {
    logic [1:0] width_mode;
    logic       direction;
  } ctl_t;

endpackage

// ----- design/lattice_coeff_compress_codec_top.sv -----
// Eight-lane coefficient compress / decompress codec, q = 3329.
// Input channel (in_valid/in_ready) takes one word: eight signed coefficients
// coeff_in_0..7 for compression, or packed_in for decompression.
// Output channel (out_valid/out_ready) returns one word per input word:
// packed_out when compressing, coeff_out_0..7 when decompressing; the
// unused side reads zero.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 sets the width mode (0: 1 bit, 1: 4 bits, 2 or 3: 5 bits),
// index 1 the direction (0 compress, 1 decompress). Write only when idle.
// The eight lane units register their results, then the merge stage packs
// or selects into the output register.
// Throughput is one word per cycle, set by the single lane stage and the
// output register; both advance together whenever the receiver takes data.
// When the receiver stalls, the output register holds and the lane stage
// keeps one more word, after which in_ready drops.
// Synchronous reset empties the pipe and sets width mode 1, compress.
module lattice_coeff_compress_codec_top import lcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [12:0] coeff_in_0,
  input  logic signed [12:0] coeff_in_1,
  input  logic signed [12:0] coeff_in_2,
  input  logic signed [12:0] coeff_in_3,
  input  logic signed [12:0] coeff_in_4,
  input  logic signed [12:0] coeff_in_5,
  input  logic signed [12:0] coeff_in_6,
  input  logic signed [12:0] coeff_in_7,
  input  logic [39:0]        packed_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [39:0]        packed_out,
  output logic [11:0]        coeff_out_0,
  output logic [11:0]        coeff_out_1,
  output logic [11:0]        coeff_out_2,
  output logic [11:0]        coeff_out_3,
  output logic [11:0]        coeff_out_4,
  output logic [11:0]        coeff_out_5,
  output logic [11:0]        coeff_out_6,
  output logic [11:0]        coeff_out_7
);

  ctl_t                      cfg;
  ctl_t                      s1_ctl;
  logic                      s1_valid;
  logic                      s1_load;
  logic                      out_load;
  logic signed [COEFF_W-1:0] coeff_arr [NUM_LANES];
  code_t                     code_arr  [NUM_LANES];
  code_t                     comp_arr  [NUM_LANES];
  dcoeff_t                   dec_arr   [NUM_LANES];
  dcoeff_t                   merged    [NUM_LANES];
  logic [PACKED_W-1:0]       packed_next;
  dcoeff_t                   coeff_q   [NUM_LANES];

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_mode <= WM_D4;
      cfg.direction  <= DIR_COMPRESS;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH_MODE) cfg.width_mode <= cfg_data;
      if (cfg_index == REG_DIRECTION)  cfg.direction  <= cfg_data[0];
    end
  end

  // pipe handshake
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load)       s1_valid <= 1'b1;
      else if (out_load) s1_valid <= 1'b0;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) s1_ctl <= cfg;
  end

  // lane inputs: coefficients and unpacked codes
  assign coeff_arr[0] = coeff_in_0;
  assign coeff_arr[1] = coeff_in_1;
  assign coeff_arr[2] = coeff_in_2;
  assign coeff_arr[3] = coeff_in_3;
  assign coeff_arr[4] = coeff_in_4;
  assign coeff_arr[5] = coeff_in_5;
  assign coeff_arr[6] = coeff_in_6;
  assign coeff_arr[7] = coeff_in_7;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      case (cfg.width_mode)
        WM_D1:   code_arr[i] = {4'd0, packed_in[i]};
        WM_D4:   code_arr[i] = {1'b0, packed_in[4*i +: 4]};
        default: code_arr[i] = packed_in[5*i +: 5];
      endcase
    end
  end

  // lane units
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lcc_lane u_lane (
      .clk    (clk),
      .en     (s1_load),
      .ctl    (cfg),
      .coeff  (coeff_arr[g]),
      .code   (code_arr[g]),
      .comp   (comp_arr[g]),
      .decomp (dec_arr[g])
    );
  end

  // merge stage
  lcc_merge u_merge (
    .ctl         (s1_ctl),
    .comp        (comp_arr),
    .decomp      (dec_arr),
    .packed_word (packed_next),
    .coeff       (merged)
  );

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      packed_out <= packed_next;
      for (int i = 0; i < NUM_LANES; i++) coeff_q[i] <= merged[i];
    end
  end

  assign coeff_out_0 = coeff_q[0];
  assign coeff_out_1 = coeff_q[1];
  assign coeff_out_2 = coeff_q[2];
  assign coeff_out_3 = coeff_q[3];
  assign coeff_out_4 = coeff_q[4];
  assign coeff_out_5 = coeff_q[5];
  assign coeff_out_6 = coeff_q[6];
  assign coeff_out_7 = coeff_q[7];

  // checks
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_load |=> s1_valid)
    else $error("lane stage word dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty lane stage");

  a_decomp_no_pack: assert property (@(posedge clk) disable iff (rst)
    out_load && s1_ctl.direction == DIR_DECOMPRESS |=> packed_out == '0)
    else $error("packed word not zero in decompress");

  a_d1_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_load && s1_ctl.direction == DIR_COMPRESS && s1_ctl.width_mode == WM_D1
    |=> packed_out[39:8] == '0)
    else $error("one bit packing spills above lane eight");

endmodule

// ----- design/lcc_lane.sv -----
module lcc_lane import lcc_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  ctl_t                      ctl,
  input  logic signed [COEFF_W-1:0] coeff,
  input  code_t                     code,
  output code_t                     comp,
  output dcoeff_t                   decomp
);

  logic signed [13:0] cadj;
  logic [31:0]        ext32;
  logic [31:0]        mul_in;
  logic [31:0]        mul_k;
  logic [31:0]        prod;
  logic [17:0]        x1;
  logic [36:0]        prod1;
  code_t              comp_next;
  logic [16:0]        dprod;
  logic [16:0]        dsum;
  dcoeff_t            decomp_next;

  // fold negative coefficients up by q
  assign cadj = coeff[COEFF_W-1] ? ($signed({coeff[COEFF_W-1], coeff}) + $signed(KQ))
                                 : $signed({coeff[COEFF_W-1], coeff});
  assign ext32 = {{18{cadj[13]}}, cadj};

  // shared multiply-and-shift for four and five bit modes, 32-bit wrap
  assign mul_in = (ctl.width_mode == WM_D4) ? ((ext32 << 4) + RND4) : ((ext32 << 5) + RND5);
  assign mul_k  = (ctl.width_mode == WM_D4) ? {15'd0, MUL4} : {15'd0, MUL5};
  assign prod   = mul_in * mul_k;

  // one bit mode: round(2c/q) by reciprocal multiply, keep quotient lsb
  assign x1    = {1'b0, cadj[13], cadj[13], cadj, 1'b0} + HALFQ;
  assign prod1 = {19'd0, x1} * {18'd0, RECIP_Q};

  always_comb begin
    case (ctl.width_mode)
      WM_D1:   comp_next = {4'd0, prod1[RECIP_SH]};
      WM_D4:   comp_next = {1'b0, prod[31:28]};
      default: comp_next = prod[31:27];
    endcase
  end

  // decompress: (n*q + 2^(d-1)) >> d
  assign dprod = {12'd0, code} * {3'd0, KQ};

  always_comb begin
    case (ctl.width_mode)
      WM_D1: begin
        dsum        = dprod + 17'd1;
        decomp_next = dsum[12:1];
      end
      WM_D4: begin
        dsum        = dprod + 17'd8;
        decomp_next = dsum[15:4];
      end
      default: begin
        dsum        = dprod + 17'd16;
        decomp_next = dsum[16:5];
      end
    endcase
  end

  // lane result register
  always_ff @(posedge clk) begin
    if (en) begin
      comp   <= comp_next;
      decomp <= decomp_next;
    end
  end

endmodule

// ----- design/lcc_merge.sv -----
module lcc_merge import lcc_pkg::*; (
  input  ctl_t          ctl,
  input  code_t         comp   [NUM_LANES],
  input  dcoeff_t       decomp [NUM_LANES],
  output logic [PACKED_W-1:0] packed_word,
  output dcoeff_t       coeff  [NUM_LANES]
);

  logic [PACKED_W-1:0] pack1;
  logic [PACKED_W-1:0] pack4;
  logic [PACKED_W-1:0] pack5;

  // pack lanes lsb first at each width
  always_comb begin
    pack1 = '0;
    pack4 = '0;
    pack5 = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      pack1[i]         = comp[i][0];
      pack4[4*i +: 4]  = comp[i][3:0];
      pack5[5*i +: 5]  = comp[i];
    end
  end

  // select by width and zero the unused side
  always_comb begin
    if (ctl.direction == DIR_COMPRESS) begin
      case (ctl.width_mode)
        WM_D1:   packed_word = pack1;
        WM_D4:   packed_word = pack4;
        default: packed_word = pack5;
      endcase
    end else begin
      packed_word = '0;
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      coeff[i] = (ctl.direction == DIR_DECOMPRESS) ? decomp[i] : '0;
    end
  end

endmodule

// ----- tb/lattice_coeff_compress_codec_top_tb.sv -----
module lattice_coeff_compress_codec_top_tb;
  import lcc_pkg::*;

  // width mode code three decodes like five bits, spare index hits no register
  localparam logic [1:0] WM_D5_ALIAS = 2'd3;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  localparam int RAND_PHASES     = 11;
  localparam int WORDS_PER_PHASE = 41;
  localparam int IDLE_MAX        = 11;
  localparam int LONG_HOLD       = 48;
  localparam int HOLD_AT_A       = 150;
  localparam int HOLD_AT_B       = 330;
  localparam int DRAIN_TAIL      = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 100;

  typedef logic [NUM_LANES-1:0][COEFF_W-1:0]  lanes_t;
  typedef logic [NUM_LANES-1:0][DCOEFF_W-1:0] dlanes_t;

  // one input word: eight signed lanes and a packed vector
  typedef struct packed {
    lanes_t              lane;
    logic [PACKED_W-1:0] bits;
  } group_t;

  // one output word
  typedef struct packed {
    logic [PACKED_W-1:0] bits;
    dlanes_t             lane;
  } word_t;

  // directed vector: settings, stimulus and an optional hand-written answer
  typedef struct packed {
    logic [1:0] mode;
    logic       dir;
    logic       typed;
    group_t     stim;
    word_t      want;
  } vec_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [1:0]          cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic signed [12:0]  coeff_in_0, coeff_in_1, coeff_in_2, coeff_in_3;
  logic signed [12:0]  coeff_in_4, coeff_in_5, coeff_in_6, coeff_in_7;
  logic [39:0]         packed_in;
  logic                out_valid;
  logic                out_ready;
  logic [39:0]         packed_out;
  logic [11:0]         coeff_out_0, coeff_out_1, coeff_out_2, coeff_out_3;
  logic [11:0]         coeff_out_4, coeff_out_5, coeff_out_6, coeff_out_7;

  // shadow of the register file and the words still owed by the block
  logic [1:0] cur_mode = WM_D4;
  logic       cur_dir  = DIR_COMPRESS;
  word_t      owed_words [$];

  int sender_idle_max = IDLE_MAX;
  int sink_idle_max   = IDLE_MAX;
  int mismatches      = 0;
  int words_comp      = 0;
  int words_decomp    = 0;
  int reg_writes      = 0;
  int long_holds      = 0;
  int results_seen    = 0;
  int stuck_cycles    = 0;

  lattice_coeff_compress_codec_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .coeff_in_0  (coeff_in_0),
    .coeff_in_1  (coeff_in_1),
    .coeff_in_2  (coeff_in_2),
    .coeff_in_3  (coeff_in_3),
    .coeff_in_4  (coeff_in_4),
    .coeff_in_5  (coeff_in_5),
    .coeff_in_6  (coeff_in_6),
    .coeff_in_7  (coeff_in_7),
    .packed_in   (packed_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_out  (packed_out),
    .coeff_out_0 (coeff_out_0),
    .coeff_out_1 (coeff_out_1),
    .coeff_out_2 (coeff_out_2),
    .coeff_out_3 (coeff_out_3),
    .coeff_out_4 (coeff_out_4),
    .coeff_out_5 (coeff_out_5),
    .coeff_out_6 (coeff_out_6),
    .coeff_out_7 (coeff_out_7)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // lane reduction and packing, or unpacking and scaling back to mod q
  function automatic word_t codec_result(group_t g, logic [1:0] mode, logic dir);
    word_t               r;
    int                  d;
    int                  c;
    logic [31:0]         s;
    logic [31:0]         u;
    logic [31:0]         quo;
    logic [31:0]         nv;
    logic [31:0]         val;
    logic [PACKED_W-1:0] code;
    logic [PACKED_W-1:0] mask;
    r = '0;
    case (mode)
      WM_D1:   d = 1;
      WM_D4:   d = 4;
      default: d = 5;
    endcase
    mask = (40'd1 << d) - 40'd1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (dir == DIR_COMPRESS) begin
        c = $signed(g.lane[i]);
        if (c < 0) c = c + int'(KQ);
        s = c;
        if (d == 1) begin
          // rounded 2c/q on the low 16 bits, parity of the quotient
          u = {16'h0, s[15:0]};
          quo = ((u << 1) + HALFQ) / KQ;
          code = {39'h0, quo[0]};
        end else if (d == 4) begin
          s = s << 4;
          s = s + RND4;
          s = s * MUL4;
          code = {36'h0, s[31:28]};
        end else begin
          s = s << 5;
          s = s + RND5;
          s = s * MUL5;
          code = {35'h0, s[31:27]};
        end
        r.bits = r.bits | ((code & mask) << (d * i));
      end else begin
        nv = 32'((g.bits >> (d * i)) & mask);
        val = (nv * int'(KQ) + (32'd1 << (d - 1))) >> d;
        r.lane[i] = val[11:0];
      end
    end
    return r;
  endfunction

  function automatic vec_row_t mk_row(logic [1:0] m, logic dr, lanes_t l,
                                      logic [PACKED_W-1:0] b, logic typed, word_t w);
    vec_row_t v;
    v.mode = m;
    v.dir = dr;
    v.typed = typed;
    v.stim.lane = l;
    v.stim.bits = b;
    v.want = w;
    return v;
  endfunction

  // random word: mostly in-range lanes, some edges and raw 13-bit noise
  function automatic group_t random_group();
    group_t g;
    int     v;
    for (int i = 0; i < NUM_LANES; i++) begin
      case ($urandom_range(0, 9))
        0: g.lane[i] = 13'($urandom);
        1: begin
          case ($urandom_range(0, 7))
            0: g.lane[i] = 13'h1000;  // -4096
            1: g.lane[i] = 13'h0FFF;  // 4095
            2: g.lane[i] = 13'h12FF;  // -q
            3: g.lane[i] = 13'h0D01;  // q
            4: g.lane[i] = 13'h1300;  // -(q-1)
            5: g.lane[i] = 13'h0D00;  // q-1
            6: g.lane[i] = 13'h1FFF;  // -1
            default: g.lane[i] = 13'h0681;
          endcase
        end
        default: begin
          v = $urandom_range(0, 6656);
          v = v - 3328;
          g.lane[i] = v[12:0];
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0:       g.bits = '1;
      1:       g.bits = '0;
      default: g.bits = 40'({$urandom, $urandom});
    endcase
    return g;
  endfunction

  // field compare against the oldest owed word
  task automatic note_mismatch(string field, logic [PACKED_W-1:0] want,
                               logic [PACKED_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch %s: expected 'h%0h, actual 'h%0h", $time, field, want, got);
  endtask

  task automatic check_word(word_t got);
    word_t oldest;
    if (owed_words.size() == 0) begin
      mismatches++;
      $display("%0t word with nothing owed: expected none, actual packed_out 'h%0h",
               $time, got.bits);
      return;
    end
    oldest = owed_words.pop_front();
    if (got.bits !== oldest.bits) note_mismatch("packed_out", oldest.bits, got.bits);
    for (int i = 0; i < NUM_LANES; i++) begin
      if (got.lane[i] !== oldest.lane[i])
        note_mismatch($sformatf("coeff_out_%0d", i), {28'h0, oldest.lane[i]},
                      {28'h0, got.lane[i]});
    end
  endtask

  // register writes once the block is empty, valid held across the burst
  task automatic program_regs(logic [1:0] mode, logic [1:0] dir_data, bit poke_spare);
    logic [1:0] idx [3];
    logic [1:0] val [3];
    int         n;
    idx[0] = REG_WIDTH_MODE;
    val[0] = mode;
    idx[1] = REG_DIRECTION;
    val[1] = dir_data;
    idx[2] = REG_SPARE;
    val[2] = 2'($urandom);
    n = poke_spare ? 3 : 2;
    while (owed_words.size() != 0) @(posedge clk);
    for (int w = 0; w < n; w++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[w];
      cfg_data <= val[w];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[w])
        REG_WIDTH_MODE: cur_mode = val[w];
        REG_DIRECTION:  cur_dir = val[w][0];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // offer one word, log what it owes, then optionally drop valid for a while
  task automatic send_group(group_t g, word_t want, int idle_after);
    in_valid <= 1'b1;
    coeff_in_0 <= g.lane[0];
    coeff_in_1 <= g.lane[1];
    coeff_in_2 <= g.lane[2];
    coeff_in_3 <= g.lane[3];
    coeff_in_4 <= g.lane[4];
    coeff_in_5 <= g.lane[5];
    coeff_in_6 <= g.lane[6];
    coeff_in_7 <= g.lane[7];
    packed_in <= g.bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_words.push_back(want);
    if (cur_dir == DIR_COMPRESS) words_comp++;
    else words_decomp++;
    if (idle_after > 0) begin
      in_valid <= 1'b0;
      repeat (idle_after) @(posedge clk);
    end
  endtask

  // output side: random stalls plus two long holds to back up the pipe
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) begin
        n = LONG_HOLD;
        long_holds++;
      end else begin
        n = $urandom_range(0, sink_idle_max);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_word({packed_out, coeff_out_7, coeff_out_6, coeff_out_5, coeff_out_4,
                  coeff_out_3, coeff_out_2, coeff_out_1, coeff_out_0});
      results_seen++;
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus
  initial begin
    vec_row_t   vec_rows [$];
    group_t     g;
    logic [1:0] mode;
    logic [1:0] dir_data;
    bit         last_in_run;
    int         idle;

    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    coeff_in_0 = '0;
    coeff_in_1 = '0;
    coeff_in_2 = '0;
    coeff_in_3 = '0;
    coeff_in_4 = '0;
    coeff_in_5 = '0;
    coeff_in_6 = '0;
    coeff_in_7 = '0;
    packed_in = '0;

    // directed vectors, hand answers where they are obvious
    // reset settings: four bits, compress
    vec_rows.push_back(mk_row(WM_D4, DIR_COMPRESS, '0, '0, 1'b1, '0));
    vec_rows.push_back(mk_row(WM_D4, DIR_COMPRESS, {8{13'h0D00}}, '0, 1'b0, '0));
    vec_rows.push_back(mk_row(WM_D4, DIR_COMPRESS, {8{13'h1300}}, '0, 1'b0, '0));
    // out-of-range lanes: -4096, 4095, -q, q, 1, -1, 832, -832
    vec_rows.push_back(mk_row(WM_D4, DIR_COMPRESS,
      {13'h1000, 13'h0FFF, 13'h12FF, 13'h0D01, 13'h0001, 13'h1FFF, 13'h0340, 13'h1CC0},
      '0, 1'b0, '0));
    vec_rows.push_back(mk_row(WM_D4, DIR_COMPRESS,
      {13'h0B60, 13'h09C0, 13'h0820, 13'h0680, 13'h04E0, 13'h0340, 13'h01A0, 13'h0000},
      '0, 1'b0, '0));
    vec_rows.push_back(mk_row(WM_D4, DIR_DECOMPRESS, '0, '0, 1'b1, '0));
    // all ones, top byte beyond the used bits
    vec_rows.push_back(mk_row(WM_D4, DIR_DECOMPRESS, '0, '1, 1'b1,
      {40'h0, {NUM_LANES{12'd3121}}}));
    vec_rows.push_back(mk_row(WM_D4, DIR_DECOMPRESS, '0, 40'h0123456789, 1'b0, '0));
    // single bit lanes
    vec_rows.push_back(mk_row(WM_D1, DIR_DECOMPRESS, '0, '1, 1'b1,
      {40'h0, {NUM_LANES{12'd1665}}}));
    vec_rows.push_back(mk_row(WM_D1, DIR_DECOMPRESS, '0, 40'hFFFFFFFF5A, 1'b0, '0));
    vec_rows.push_back(mk_row(WM_D1, DIR_COMPRESS, {8{13'h0681}}, '0, 1'b1,
      {40'hFF, 96'h0}));
    vec_rows.push_back(mk_row(WM_D1, DIR_COMPRESS, '0, '0, 1'b1, '0));
    // rounding edges 832/833, 2496/2497 plus out-of-range lanes
    vec_rows.push_back(mk_row(WM_D1, DIR_COMPRESS,
      {13'h1000, 13'h0FFF, 13'h12FF, 13'h0D01, 13'h0340, 13'h0341, 13'h09C0, 13'h09C1},
      '0, 1'b0, '0));
    // five bit lanes
    vec_rows.push_back(mk_row(WM_D5, DIR_COMPRESS, '0, '0, 1'b1, '0));
    vec_rows.push_back(mk_row(WM_D5, DIR_COMPRESS, {8{13'h0D00}}, '0, 1'b0, '0));
    vec_rows.push_back(mk_row(WM_D5, DIR_COMPRESS,
      {13'h1000, 13'h0FFF, 13'h12FF, 13'h0D01, 13'h0001, 13'h1FFF, 13'h0340, 13'h1CC0},
      '0, 1'b0, '0));
    vec_rows.push_back(mk_row(WM_D5, DIR_COMPRESS,
      {13'h1300, 13'h14A0, 13'h1980, 13'h1E60, 13'h0D00, 13'h0B60, 13'h0680, 13'h01A0},
      '0, 1'b0, '0));
    vec_rows.push_back(mk_row(WM_D5, DIR_DECOMPRESS, '0, '1, 1'b1,
      {40'h0, {NUM_LANES{12'd3225}}}));
    vec_rows.push_back(mk_row(WM_D5, DIR_DECOMPRESS, '0, 40'h8421084210, 1'b0, '0));
    // mode code three behaves as five bits
    vec_rows.push_back(mk_row(WM_D5_ALIAS, DIR_DECOMPRESS, '0, '1, 1'b1,
      {40'h0, {NUM_LANES{12'd3225}}}));
    vec_rows.push_back(mk_row(WM_D5_ALIAS, DIR_COMPRESS,
      {13'h0B60, 13'h09C0, 13'h0820, 13'h0680, 13'h04E0, 13'h0340, 13'h01A0, 13'h0000},
      '0, 1'b0, '0));

    // reset
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed pass
    for (int r = 0; r < vec_rows.size(); r++) begin
      if (vec_rows[r].mode != cur_mode || vec_rows[r].dir != cur_dir)
        program_regs(vec_rows[r].mode, {1'b0, vec_rows[r].dir}, 1'b0);
      last_in_run = (r == vec_rows.size() - 1) ||
                    vec_rows[r+1].mode != vec_rows[r].mode ||
                    vec_rows[r+1].dir != vec_rows[r].dir;
      idle = last_in_run ? 1 : $urandom_range(0, sender_idle_max);
      send_group(vec_rows[r].stim,
                 vec_rows[r].typed ? vec_rows[r].want
                                   : codec_result(vec_rows[r].stim, cur_mode, cur_dir),
                 idle);
    end

    // random phases: every mode in both directions first, then random settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 8) begin
        mode = ph[1:0];
        dir_data[0] = ph[2];
      end else begin
        mode = 2'($urandom_range(0, 3));
        dir_data[0] = 1'($urandom_range(0, 1));
      end
      dir_data[1] = 1'($urandom_range(0, 1));
      case (ph % 3)
        0: begin
          sender_idle_max = IDLE_MAX;
          sink_idle_max = IDLE_MAX;
        end
        1: begin
          sender_idle_max = 0;
          sink_idle_max = IDLE_MAX;
        end
        default: begin
          sender_idle_max = IDLE_MAX;
          sink_idle_max = 0;
        end
      endcase
      if (ph == RAND_PHASES - 1) begin
        sender_idle_max = 0;
        sink_idle_max = 0;
      end
      program_regs(mode, dir_data, ph == 0);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        g = random_group();
        idle = (k == WORDS_PER_PHASE - 1) ? 1 : $urandom_range(0, sender_idle_max);
        send_group(g, codec_result(g, cur_mode, cur_dir), idle);
      end
    end

    // drain and look for stray words
    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("covered %0d compress and %0d decompress words over %0d register writes",
             words_comp, words_decomp, reg_writes);
    $display("all width modes both ways, %0d long output holds, %0d mismatches",
             long_holds, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lcc_pkg.sv
design/lcc_lane.sv
design/lcc_merge.sv
design/lattice_coeff_compress_codec_top.sv
tb/lattice_coeff_compress_codec_top_tb.sv
